/* hw/rtl/acs_pkg.sv */
// Shared types and constants for the axis cumulative sum block.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

    localparam int SUM_W        = 32;
    localparam int INNER_CNT_W  = 11;
    localparam int AXIS_LEN_W   = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 4;
    localparam int LIMIT_W      = 17;

    typedef enum logic [1:0] {
        REG_INNER_CNT   = 2'd0,
        REG_AXIS_LENGTH = 2'd1,
        REG_EXCLUSIVE   = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

/* hw/rtl/acs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module acs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/axis_cumulative_sum.sv */
// Top level of the axis cumulative sum block: counters, accumulator RAM, output register.
// The block takes one sample per clock and gives one running sum per sample via the
// accumulate and output registers. Running sums for each inner index live in a
// one-port-read, one-port-write RAM of MAX_INNER words; a sample reads its sum at the
// transfer in and adds and writes it back as it advances, and a sum written in the same
// cycle as the read of the next sample is forwarded, so back-to-back samples to one inner
// index run at full rate. Rate is one transfer per cycle, limited only by output stall.
// Sums restart at the first axis position of every run, so the RAM needs no clearing
// after reset. Configuration writes must happen while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module axis_cumulative_sum #(
    parameter int MAX_INNER    = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [acs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [acs_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [acs_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [acs_pkg::SUM_W-1:0]        o_running_sum,
    output logic                                    o_slice_last
);

    import acs_pkg::*;

    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam logic [LIMIT_W-1:0] MAX_M1 = LIMIT_W'(MAX_INNER - 1);
    localparam logic [LIMIT_W-1:0] MAX_LIM = LIMIT_W'(MAX_INNER);

    // Configuration registers
    logic [INNER_CNT_W-1:0]  r_inner_cnt;
    logic [AXIS_LEN_W-1:0]   r_axis_length;
    logic                    r_exclusive;
    logic                    cfg_wr;
    t_reg_idx                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_cnt   <= INNER_CNT_W'(1);
            r_axis_length <= AXIS_LEN_W'(1);
            r_exclusive   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INNER_CNT:   r_inner_cnt   <= pwdata[INNER_CNT_W-1:0];
                REG_AXIS_LENGTH: r_axis_length <= pwdata[AXIS_LEN_W-1:0];
                REG_EXCLUSIVE:   r_exclusive   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INNER_CNT:   prdata = CFG_DATA_W'(r_inner_cnt);
            REG_AXIS_LENGTH: prdata = CFG_DATA_W'(r_axis_length);
            REG_EXCLUSIVE:   prdata = CFG_DATA_W'(r_exclusive);
            default:         prdata = '0;
        endcase
    end

    // Last valid indexes; zero sizes act as one, oversized inner size is clamped.
    logic [LIMIT_W-1:0]    inner_lim;
    logic [AXIS_LEN_W-1:0] axis_lim;

    always_comb begin
        if (r_inner_cnt == '0) begin
            inner_lim = '0;
        end else if (LIMIT_W'(r_inner_cnt) > MAX_LIM) begin
            inner_lim = MAX_M1;
        end else begin
            inner_lim = LIMIT_W'(r_inner_cnt) - LIMIT_W'(1);
        end
        axis_lim = (r_axis_length == '0) ? '0 : r_axis_length - AXIS_LEN_W'(1);
    end

    // Position counters and first stage
    logic [IW-1:0]         r_inner_pos;
    logic [AXIS_LEN_W-1:0] r_axis_pos;
    logic                  acc_in;
    logic                  last_inner;
    logic                  last_axis;

    logic                  r_s1_valid;
    logic [IW-1:0]         r_s1_slot;
    logic                  r_s1_first;
    logic                  r_s1_last;
    logic [SUM_W-1:0]      r_s1_sample;
    logic                  r_s1_fwd;
    logic [SUM_W-1:0]      r_fwd_data;
    logic                  s1_adv;
    logic [SUM_W-1:0]      s1_before;
    logic [SUM_W-1:0]      s1_after;
    logic [SUM_W-1:0]      ram_rdata;

    assign s1_adv     = r_s1_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign acc_in     = i_in_valid && !o_in_stall;
    assign last_inner = LIMIT_W'(r_inner_pos) >= inner_lim;
    assign last_axis  = r_axis_pos >= axis_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_pos <= '0;
            r_axis_pos  <= '0;
        end else if (acc_in) begin
            if (last_inner) begin
                r_inner_pos <= '0;
                r_axis_pos  <= last_axis ? '0 : r_axis_pos + AXIS_LEN_W'(1);
            end else begin
                r_inner_pos <= r_inner_pos + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_in) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // A write-back in the same cycle as the read of the same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_slot   <= r_inner_pos;
            r_s1_first  <= (r_axis_pos == '0);
            r_s1_last   <= last_inner && last_axis;
            r_s1_sample <= SUM_W'(i_sample);
            r_s1_fwd    <= s1_adv && (r_s1_slot == r_inner_pos);
            r_fwd_data  <= s1_after;
        end
    end

    always_comb begin
        if (r_s1_first) begin
            s1_before = '0;
        end else if (r_s1_fwd) begin
            s1_before = r_fwd_data;
        end else begin
            s1_before = ram_rdata;
        end
        s1_after = s1_before + r_s1_sample;
    end

    acs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_INNER)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_slot),
        .i_wdata (s1_after),
        .i_re    (acc_in),
        .i_raddr (r_inner_pos),
        .o_rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_running_sum <= r_exclusive ? s1_before : s1_after;
            o_slice_last  <= r_s1_last;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with no item in the accumulate stage");

    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("accumulate stage dropped an item");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_s1_valid)
        else $error("accepted transfer did not reach the accumulate stage");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("advanced item did not reach the output register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
